// ===== rtl/segment_clip_to_rectangle_macros.svh =====
// Assertion macros for the segment clipping block.
`ifndef SEGMENT_CLIP_TO_RECTANGLE_MACROS_SVH
`define SEGMENT_CLIP_TO_RECTANGLE_MACROS_SVH
// check a same-cycle implication on the block clock
`define SCR_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// check an implication in the next cycle
`define SCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/scr_pkg.sv =====
// Shared constants for the segment clipping block.
package scr_pkg;
   localparam int EDGE_W = 4;
   localparam int FW_W = 15;
   localparam int FL_W = 15;
   localparam int T_W = 12;
   localparam int CSR_DATA_W = 15;
   localparam int CSR_INDEX_W = 2;
   localparam int WALLS = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_X_SPAN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_SPAN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_INSET = 2'd2;

   localparam logic [FW_W-1:0] X_SPAN_RESET = 15'd5760;
   localparam logic [FL_W-1:0] Y_SPAN_RESET = 15'd8640;
   localparam logic [T_W-1:0] INSET_RESET = 12'd160;

   localparam logic [EDGE_W-1:0] EDGE_NONE = 4'd0;
   localparam logic [EDGE_W-1:0] EDGE_INNER_LEFT = 4'd1;
endpackage

// ===== rtl/scr_if.sv =====
// Request and response channel interfaces of the segment clipping block.
interface scr_req_if #(parameter int COORD_BITS = 16);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface scr_rsp_if #(parameter int COORD_BITS = 16);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] clipped_x;
   logic signed [COORD_BITS-1:0] clipped_y;
   logic [scr_pkg::EDGE_W-1:0] edge_hit;
   modport source (output valid, clipped_x, clipped_y, edge_hit, input ready);
   modport sink (input valid, clipped_x, clipped_y, edge_hit, output ready);
endinterface

// ===== rtl/segment_clip_to_rectangle.sv =====
// Top level of the segment clipping block: pipelined wall crossing search.
// Usage:
//   req_chan carries a segment (start_x, start_y, end_x, end_y); rsp_chan
//   returns the clipped end point and edge_hit (0 none, 1-4 inner left,
//   right, bottom, top, 5-8 outer in the same order).
//   The csr port writes the x extent (0), the y extent (1) and the wall
//   inset (2); write only while no request is in flight.
// Pipeline: an accepted request reaches response valid
//   through COORD_BITS + 5 register stages: input register, wall setup,
//   magnitude multiply, one stage per quotient bit of the eight restoring
//   dividers (COORD_BITS + 1), then selection into the output register.
// Throughput: one request per cycle unless the receiver stalls; the eight divider pipelines are fully pipelined.
// Reset clears all valid bits and loads the default field geometry.
// When the receiver stalls, the whole pipeline holds and req_chan.ready
// drops; nothing is lost or repeated.
`include "segment_clip_to_rectangle_macros.svh"
module segment_clip_to_rectangle #(
   parameter int COORD_BITS = 16
) (
   input logic clock,
   input logic reset,
   scr_req_if.sink req_chan,
   scr_rsp_if.source rsp_chan,
   input logic csr_write,
   input logic [scr_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [scr_pkg::CSR_DATA_W-1:0] csr_data
);
   import scr_pkg::*;

   localparam int N = COORD_BITS;
   localparam int AW = ((N > 16) ? N : 16) + 2;
   localparam int PW = 2 * AW;
   localparam int QW = N + 1;
   localparam int LAST = QW + 2;

   typedef struct packed {
      logic signed [N-1:0] cx;
      logic signed [N-1:0] cy;
      logic signed [N-1:0] px;
      logic signed [N-1:0] py;
   } pts_type;

   typedef struct packed {
      logic ok;
      logic neg;
      logic [AW-1:0] ma;
      logic [AW-1:0] mb;
      logic [AW-1:0] mc;
   } prep_type;

   typedef struct packed {
      logic ok;
      logic neg;
      logic [PW-1:0] rem;
      logic [AW-1:0] dvs;
      logic [QW-1:0] q;
   } div_type;

   function automatic div_type div_step(div_type d, int k);
      logic [PW-1:0] sh;
      div_type n;
      n = d;
      sh = PW'(d.dvs) << (QW - 1 - k);
      if (d.rem >= sh) begin
         n.rem = d.rem - sh;
         n.q = d.q | (QW'(1) << (QW - 1 - k));
      end
      return n;
   endfunction

   logic [FW_W-1:0] fw_ff;
   logic [FL_W-1:0] fl_ff;
   logic [T_W-1:0] t_ff;

   logic adv;
   logic [LAST:0] valid_ff;
   pts_type pts_ff [0:LAST];
   prep_type prep_in [WALLS];
   prep_type prep_ff [WALLS];
   div_type div_ff [0:QW][WALLS];

   logic signed [AW-1:0] v_w [WALLS];
   logic signed [AW-1:0] lo_w [WALLS];
   logic signed [AW-1:0] hi_w [WALLS];

   logic out_valid_ff;
   logic signed [N-1:0] out_x_ff, out_x_in;
   logic signed [N-1:0] out_y_ff, out_y_in;
   logic [EDGE_W-1:0] out_e_ff, out_e_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= X_SPAN_RESET;
         fl_ff <= Y_SPAN_RESET;
         t_ff <= INSET_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_X_SPAN: fw_ff <= csr_data[FW_W-1:0];
            REG_Y_SPAN: fl_ff <= csr_data[FL_W-1:0];
            REG_INSET: t_ff <= csr_data[T_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic signed [AW-1:0] fw, fl, t;
      fw = signed'(AW'(fw_ff));
      fl = signed'(AW'(fl_ff));
      t = signed'(AW'(t_ff));
      for (int w = 0; w < WALLS; w++) begin
         logic signed [AW-1:0] xl, xh, yl, yh;
         xl = (w >= 4) ? '0 : t;
         xh = (w >= 4) ? fw : fw - t;
         yl = (w >= 4) ? '0 : t;
         yh = (w >= 4) ? fl : fl - t;
         case (w % 4)
            0: begin v_w[w] = xl; lo_w[w] = yl; hi_w[w] = yh; end
            1: begin v_w[w] = xh; lo_w[w] = yl; hi_w[w] = yh; end
            2: begin v_w[w] = yl; lo_w[w] = xl; hi_w[w] = xh; end
            default: begin v_w[w] = yh; lo_w[w] = xl; hi_w[w] = xh; end
         endcase
      end
   end

   assign adv = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAST-1:0], req_chan.valid};
         out_valid_ff <= valid_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pts_ff[0] <= '{cx: req_chan.start_x, cy: req_chan.start_y,
                        px: req_chan.end_x, py: req_chan.end_y};
         for (int s = 1; s <= LAST; s++) pts_ff[s] <= pts_ff[s-1];
      end
   end

   // wall setup: side, span and difference magnitudes
   always_comb begin
      for (int w = 0; w < WALLS; w++) begin
         logic signed [AW-1:0] ca, cb, pa, pb, d1, d2, db, dc;
         logic side;
         if (w % 4 < 2) begin
            ca = AW'(pts_ff[0].cx); cb = AW'(pts_ff[0].cy);
            pa = AW'(pts_ff[0].px); pb = AW'(pts_ff[0].py);
         end else begin
            ca = AW'(pts_ff[0].cy); cb = AW'(pts_ff[0].cx);
            pa = AW'(pts_ff[0].py); pb = AW'(pts_ff[0].px);
         end
         d1 = v_w[w] - ca;
         d2 = v_w[w] - pa;
         db = cb - pb;
         dc = ca - pa;
         side = (w % 2 == 0) ? (ca > v_w[w]) : (ca < v_w[w]);
         prep_in[w].ok = side && (ca != pa) &&
            !(((d1 > 0) && (d2 > 0)) || ((d1 < 0) && (d2 < 0)));
         prep_in[w].neg = (d1 < 0) ^ (db < 0) ^ (dc < 0);
         prep_in[w].ma = (d1 < 0) ? -d1 : d1;
         prep_in[w].mb = (db < 0) ? -db : db;
         prep_in[w].mc = (dc < 0) ? -dc : dc;
      end
   end

   // wall setup register, magnitude multiply and restoring divider: one quotient bit per stage, most significant first
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int w = 0; w < WALLS; w++) begin
            prep_ff[w] <= prep_in[w];
            div_ff[0][w] <= '{ok: prep_ff[w].ok, neg: prep_ff[w].neg,
                              rem: PW'(prep_ff[w].ma) * PW'(prep_ff[w].mb),
                              dvs: prep_ff[w].mc, q: QW'(0)};
            for (int k = 0; k < QW; k++) div_ff[k+1][w] <= div_step(div_ff[k][w], k);
         end
      end
   end

   // range test and first-wall selection
   always_comb begin
      logic signed [AW:0] res [WALLS];
      logic hit [WALLS];
      for (int w = 0; w < WALLS; w++) begin
         logic signed [AW:0] qv, cbv, lo, hi;
         qv = signed'((AW + 1)'(div_ff[QW][w].q));
         cbv = (w % 4 < 2) ? (AW + 1)'(pts_ff[LAST].cy) : (AW + 1)'(pts_ff[LAST].cx);
         lo = (AW + 1)'(lo_w[w]);
         hi = (AW + 1)'(hi_w[w]);
         res[w] = (div_ff[QW][w].neg ? -qv : qv) + cbv;
         hit[w] = div_ff[QW][w].ok &&
            !(((res[w] > lo) && (res[w] > hi)) || ((res[w] < lo) && (res[w] < hi)));
      end
      out_x_in = pts_ff[LAST].px;
      out_y_in = pts_ff[LAST].py;
      out_e_in = EDGE_NONE;
      for (int w = WALLS - 1; w >= 0; w--) begin
         if (hit[w]) begin
            out_e_in = EDGE_W'(w + 1);
            if (w % 4 < 2) begin
               out_x_in = v_w[w][N-1:0];
               out_y_in = res[w][N-1:0];
            end else begin
               out_x_in = res[w][N-1:0];
               out_y_in = v_w[w][N-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_e_ff <= out_e_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.clipped_x = out_x_ff;
   assign rsp_chan.clipped_y = out_y_ff;
   assign rsp_chan.edge_hit = out_e_ff;

   `SCR_ASSERT_IMPLY(a_edge_range, rsp_chan.valid, rsp_chan.edge_hit <= 4'd8, "edge code out of range")
   `SCR_ASSERT_IMPLY(a_stall_blocks, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready, "request taken during stall")
   `SCR_ASSERT_IMPLY(a_inner_left_x, rsp_chan.valid && rsp_chan.edge_hit == EDGE_INNER_LEFT, rsp_chan.clipped_x == N'(t_ff), "inner left crossing off wall")
   `SCR_ASSERT_NEXT(a_hold_valid, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid && $stable(rsp_chan.clipped_x), "stalled response dropped")
endmodule
